>>> design/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg: shared types and constants of the RGB LED strip serializer
// Command codes, store geometry, and the structs passed between modules.
// ----------------------------------------------------------------------------
package rls_pkg;

  // Pixel store geometry (the index field is 8 bits wide, so the store is fixed)
  localparam int MAX_PIXELS = 256;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int PIX_W      = 24;
  localparam int COUNT_W    = 9;

  // Default length of a clear sequence, in zero bytes
  localparam int CLEAR_BYTES = 100;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } item_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic error;
    logic done_res;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [PIX_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_req_t;

endpackage

>>> design/rls_if.sv
// ----------------------------------------------------------------------------
// rls_if: command and result channels of the RGB LED strip serializer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rls_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, pixel_index, red, green, blue, input ready);
  modport sink   (input valid, func, pixel_index, red, green, blue, output ready);
endinterface

interface rls_rsp_if;
  logic valid;
  logic ready;
  logic clock_line;
  logic data_line;
  logic busy_res;
  logic error;
  logic done_res;

  modport source (output valid, clock_line, data_line, busy_res, error, done_res,
                  input ready);
  modport sink   (input valid, clock_line, data_line, busy_res, error, done_res,
                  output ready);
endinterface

>>> design/rgb_led_strip_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer: frame buffer and two-wire LED strip driver
// Stores 24-bit pixels and shifts them out on a clock/data pair, one
// half-bit per tick command.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle and returns exactly one result
// per command from a single output register, visible in the cycle after its
// transfer; a command is taken whenever that register is empty or its
// result is being taken in the same cycle. Commands are: write a pixel,
// start an update (send pixel_count pixels as red, green, blue, MSB first),
// start a clear (send CLEAR_BYTES zero bytes), and tick (advance one half-bit:
// the first half drops the clock and sets data, the second raises the clock).
// A write at or beyond pixel_count, or a start while a sequence is running,
// sets error. The pixel store reads back zero for pixels never written since
// reset and is read live, so a pixel rewritten before it goes out is sent with
// its new value. Write pixel_count only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer #(
  parameter int CLEAR_BYTES = rls_pkg::CLEAR_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  rls_req_if.sink                     req,
  rls_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [rls_pkg::COUNT_W-1:0] cfg_wdata
);

  logic [rls_pkg::COUNT_W-1:0] pixel_count;
  logic                        accept;
  rls_pkg::item_t              item;
  rls_pkg::result_t            result;
  rls_pkg::result_t            rsp_data;
  rls_pkg::wr_req_t            wr;
  logic [rls_pkg::PIX_AW-1:0]  rd_addr;
  logic [rls_pkg::PIX_W-1:0]   rd_data;
  logic                        rd_valid;
  logic                        rsp_valid;

  // Pixel count register; reset to one pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= rls_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      pixel_count <= cfg_wdata;
    end
  end

  // Accept a command when the result register is free or draining this cycle
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item.func        = rls_pkg::func_t'(req.func);
  assign item.pixel_index = req.pixel_index;
  assign item.red         = req.red;
  assign item.green       = req.green;
  assign item.blue        = req.blue;

  rls_pixel_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  rls_bit_sequencer #(
    .CLEAR_BYTES (CLEAR_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .pixel_count (pixel_count),
    .rd_data     (rd_data),
    .rd_valid    (rd_valid),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .result      (result)
  );

  // Result register: load on every command transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.clock_line = rsp_data.clock_line;
  assign rsp.data_line  = rsp_data.data_line;
  assign rsp.busy_res   = rsp_data.busy_res;
  assign rsp.error      = rsp_data.error;
  assign rsp.done_res   = rsp_data.done_res;

  // Every command transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("result missing after command transfer");

  // A finished sequence leaves the clock high and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.done_res |-> rsp.clock_line && !rsp.busy_res)
    else $error("done flagged with clock low or still busy");

  // Ticks never report an error
  a_tick_no_error: assert property (@(posedge clk) disable iff (rst)
    accept && (item.func == rls_pkg::FUNC_TICK) |=> !rsp.error)
    else $error("error flagged on a tick");

  // Done only ever comes from a tick
  a_done_on_tick: assert property (@(posedge clk) disable iff (rst)
    accept && (item.func != rls_pkg::FUNC_TICK) |=> !rsp.done_res)
    else $error("done flagged on a non-tick command");

endmodule

>>> design/rls_pixel_ram.sv
// ----------------------------------------------------------------------------
// rls_pixel_ram: pixel frame buffer
// One write port, one registered read port with write-through forwarding.
// Per-entry valid bits make unwritten pixels read as zero after reset.
// ----------------------------------------------------------------------------
module rls_pixel_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  rls_pkg::wr_req_t            wr,
  input  logic [rls_pkg::PIX_AW-1:0]  rd_addr,
  output logic [rls_pkg::PIX_W-1:0]   rd_data,
  output logic                        rd_valid
);

  logic [rls_pkg::PIX_W-1:0]      mem [rls_pkg::MAX_PIXELS];
  logic [rls_pkg::MAX_PIXELS-1:0] written;
  logic [rls_pkg::PIX_W-1:0]      mem_q;
  logic [rls_pkg::PIX_W-1:0]      fwd_data;
  logic                           fwd_hit;
  logic                           entry_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written     <= '0;
      fwd_hit     <= 1'b0;
      entry_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      fwd_hit     <= wr.en && (wr.addr == rd_addr);
      entry_valid <= written[rd_addr] || (wr.en && (wr.addr == rd_addr));
    end
  end

  // hold the write data for the cycle the array read still shows old contents
  always_ff @(posedge clk) begin
    fwd_data <= wr.data;
  end

  assign rd_data  = fwd_hit ? fwd_data : mem_q;
  assign rd_valid = entry_valid;

endmodule

>>> design/rls_bit_sequencer.sv
// ----------------------------------------------------------------------------
// rls_bit_sequencer: command decode and half-bit serializer
// Steps bit, byte and pixel counters one half-bit per tick and picks the
// outgoing data bit from the live pixel word.
// ----------------------------------------------------------------------------
module rls_bit_sequencer #(
  parameter int CLEAR_BYTES = rls_pkg::CLEAR_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  rls_pkg::item_t                item,
  input  logic [rls_pkg::COUNT_W-1:0]   pixel_count,
  input  logic [rls_pkg::PIX_W-1:0]     rd_data,
  input  logic                          rd_valid,
  output logic [rls_pkg::PIX_AW-1:0]    rd_addr,
  output rls_pkg::wr_req_t              wr,
  output rls_pkg::result_t              result
);

  localparam logic [rls_pkg::COUNT_W-1:0] MAX_COUNT = rls_pkg::COUNT_W'(rls_pkg::MAX_PIXELS);
  localparam logic [6:0]                  CLEAR_LAST = 7'(CLEAR_BYTES);

  logic                         busy, busy_next;
  logic                         clear_mode, clear_mode_next;
  logic [rls_pkg::COUNT_W-1:0]  pixel_counter, pixel_counter_next;
  logic [1:0]                   byte_select, byte_select_next;
  logic [2:0]                   bit_counter, bit_counter_next;
  logic                         half_phase, half_phase_next;
  logic [6:0]                   clear_byte_counter, clear_byte_counter_next;
  logic                         clock_level, clock_level_next;
  logic                         data_level, data_level_next;
  logic [rls_pkg::COUNT_W-1:0]  eff_count;
  logic [7:0]                   cur_byte;
  logic                         err, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b0;
      clear_mode         <= 1'b0;
      pixel_counter      <= '0;
      byte_select        <= '0;
      bit_counter        <= '0;
      half_phase         <= 1'b0;
      clear_byte_counter <= '0;
      clock_level        <= 1'b0;
      data_level         <= 1'b0;
    end else begin
      busy               <= busy_next;
      clear_mode         <= clear_mode_next;
      pixel_counter      <= pixel_counter_next;
      byte_select        <= byte_select_next;
      bit_counter        <= bit_counter_next;
      half_phase         <= half_phase_next;
      clear_byte_counter <= clear_byte_counter_next;
      clock_level        <= clock_level_next;
      data_level         <= data_level_next;
    end
  end

  assign eff_count = (pixel_count > MAX_COUNT) ? MAX_COUNT : pixel_count;

  // clear sequences, pixels past the store and unwritten pixels send zero bytes
  always_comb begin
    cur_byte = 8'd0;
    if (!clear_mode && (pixel_counter < MAX_COUNT) && rd_valid) begin
      case (byte_select)
        2'd0:    cur_byte = rd_data[23:16];
        2'd1:    cur_byte = rd_data[15:8];
        2'd2:    cur_byte = rd_data[7:0];
        default: cur_byte = 8'd0;
      endcase
    end
  end

  always_comb begin
    busy_next               = busy;
    clear_mode_next         = clear_mode;
    pixel_counter_next      = pixel_counter;
    byte_select_next        = byte_select;
    bit_counter_next        = bit_counter;
    half_phase_next         = half_phase;
    clear_byte_counter_next = clear_byte_counter;
    clock_level_next        = clock_level;
    data_level_next         = data_level;
    err                     = 1'b0;
    done                    = 1'b0;
    wr.en                   = 1'b0;
    wr.addr                 = item.pixel_index;
    wr.data                 = {item.red, item.green, item.blue};

    if (accept) begin
      unique case (item.func) inside
        rls_pkg::FUNC_WRITE: begin
          if ({1'b0, item.pixel_index} < eff_count) begin
            wr.en = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        rls_pkg::FUNC_UPDATE, rls_pkg::FUNC_CLEAR: begin
          if (busy) begin
            err = 1'b1;
          end else begin
            clear_mode_next         = (item.func == rls_pkg::FUNC_CLEAR);
            pixel_counter_next      = '0;
            byte_select_next        = '0;
            bit_counter_next        = '0;
            half_phase_next         = 1'b0;
            clear_byte_counter_next = '0;
            busy_next = (item.func == rls_pkg::FUNC_CLEAR) || (eff_count != '0);
          end
        end
        rls_pkg::FUNC_TICK: begin
          if (busy) begin
            if (!half_phase) begin
              clock_level_next = 1'b0;
              data_level_next  = cur_byte[3'd7 - bit_counter];
              half_phase_next  = 1'b1;
            end else begin
              clock_level_next = 1'b1;
              half_phase_next  = 1'b0;
              if (bit_counter != 3'd7) begin
                bit_counter_next = bit_counter + 3'd1;
              end else begin
                bit_counter_next = '0;
                if (clear_mode) begin
                  clear_byte_counter_next = clear_byte_counter + 7'd1;
                  done = (clear_byte_counter_next >= CLEAR_LAST);
                end else if (byte_select < 2'd2) begin
                  byte_select_next = byte_select + 2'd1;
                end else begin
                  byte_select_next   = '0;
                  pixel_counter_next = pixel_counter + rls_pkg::COUNT_W'(1);
                  done = (pixel_counter_next >= eff_count);
                end
              end
              if (done) begin
                busy_next = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // read the pixel the next half-bit will need
  assign rd_addr = pixel_counter_next[rls_pkg::PIX_AW-1:0];

  assign result.clock_line = clock_level_next;
  assign result.data_line  = data_level_next;
  assign result.busy_res   = busy_next;
  assign result.error      = err;
  assign result.done_res   = done;

endmodule
